// ===== rtl/swde_pkg.sv =====
package swde_pkg;

  localparam int BANKS_DEF       = 2;
  localparam int BANK_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int SW_NUM_W   = 5;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

  // APB: one 32-bit register, word index taken from paddr[2]
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DEBOUNCE = 1'b0;

endpackage

// ===== rtl/swde_front.sv =====
module swde_front #(
  parameter int BANKS     = swde_pkg::BANKS_DEF,
  parameter int BANK_BITS = swde_pkg::BANK_BITS_DEF,
  parameter int BANK_W    = (BANKS > 1) ? $clog2(BANKS) : 1,
  parameter int ENTRY_W   = BANK_W + 2 * BANK_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [swde_pkg::DEBOUNCE_W-1:0]   debounce_ms,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [BANK_W-1:0]                 in_bank,
  input  logic [BANK_BITS-1:0]              in_raw_word,
  input  logic [swde_pkg::TIME_W-1:0]       in_time_ms,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [ENTRY_W-1:0]                q_wdata
);

  localparam int SLOTS = 2 ** BANK_W;

  logic [BANK_BITS-1:0]        prev_raw_r    [SLOTS];
  logic [BANK_BITS-1:0]        stable_word_r [SLOTS];
  logic [swde_pkg::TIME_W-1:0] change_time_r [SLOTS];

  logic                        accept;
  logic                        in_range;
  logic                        raw_changed;
  logic [swde_pkg::TIME_W-1:0] elapsed;
  logic                        settle;
  logic [BANK_BITS-1:0]        diff;

  assign in_stall    = q_full;
  assign accept      = in_valid && !in_stall;
  assign in_range    = ({1'b0, in_bank} < (BANK_W + 1)'(BANKS));
  assign raw_changed = (in_raw_word != prev_raw_r[in_bank]);
  assign elapsed     = in_time_ms - change_time_r[in_bank];
  assign diff        = in_raw_word ^ stable_word_r[in_bank];
  // a change on this scan never settles; it only restarts the settle time
  assign settle      = !raw_changed &&
                       (elapsed > {{(swde_pkg::TIME_W - swde_pkg::DEBOUNCE_W){1'b0}}, debounce_ms}) &&
                       (diff != '0);

  assign q_push  = accept && in_range && settle;
  assign q_wdata = {in_bank, diff, in_raw_word};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        prev_raw_r[i]    <= '0;
        stable_word_r[i] <= '0;
        change_time_r[i] <= '0;
      end
    end else if (accept && in_range) begin
      prev_raw_r[in_bank] <= in_raw_word;
      if (raw_changed) begin
        change_time_r[in_bank] <= in_time_ms;
      end
      if (settle) begin
        stable_word_r[in_bank] <= in_raw_word;
      end
    end
  end

endmodule

// ===== rtl/swde_queue.sv =====
module swde_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = swde_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W:0]   rd_ptr_r, rd_ptr_nxt;

  assign q_valid = (wr_ptr_r != rd_ptr_r);
  assign full    = (wr_ptr_r[PTR_W] != rd_ptr_r[PTR_W]) &&
                   (wr_ptr_r[PTR_W-1:0] == rd_ptr_r[PTR_W-1:0]);
  assign rdata   = mem[rd_ptr_r[PTR_W-1:0]];

  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = (pop && q_valid) ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r[PTR_W-1:0]] <= wdata;
    end
  end

endmodule

// ===== rtl/swde_back.sv =====
module swde_back #(
  parameter int BANKS     = swde_pkg::BANKS_DEF,
  parameter int BANK_BITS = swde_pkg::BANK_BITS_DEF,
  parameter int BANK_W    = (BANKS > 1) ? $clog2(BANKS) : 1,
  parameter int ENTRY_W   = BANK_W + 2 * BANK_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [ENTRY_W-1:0]            q_rdata,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swde_pkg::SW_NUM_W-1:0] out_switch_number,
  output logic                          out_level,
  output logic                          out_last_event
);

  localparam int IDX_W = $clog2(BANK_BITS);
  localparam int NUM_W = BANK_W + IDX_W + 1;

  logic                 busy_r, busy_nxt;
  logic [BANK_W-1:0]    bank_r, bank_nxt;
  logic [BANK_BITS-1:0] rem_r, rem_nxt;
  logic [BANK_BITS-1:0] raw_r, raw_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [swde_pkg::SW_NUM_W-1:0] out_num_r, out_num_nxt;
  logic                          out_level_r, out_level_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [BANK_BITS-1:0] low_bit;
  logic [IDX_W-1:0]     low_idx;
  logic                 is_last;
  logic                 advance;
  logic [NUM_W-1:0]     num;

  assign low_bit = rem_r & (~rem_r + 1'b1);
  assign is_last = ((rem_r & ~low_bit) == '0);

  always_comb begin
    low_idx = '0;
    for (int i = BANK_BITS - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign num = NUM_W'(bank_r) * NUM_W'(BANK_BITS) + NUM_W'(low_idx);

  assign advance = busy_r && (!out_valid_r || !out_stall);
  // refill the work slot as soon as the current scan's final event leaves
  assign q_pop   = q_valid && (!busy_r || (advance && is_last));

  always_comb begin
    busy_nxt = busy_r;
    bank_nxt = bank_r;
    rem_nxt  = rem_r;
    raw_nxt  = raw_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      {bank_nxt, rem_nxt, raw_nxt} = q_rdata;
    end else if (advance) begin
      rem_nxt  = rem_r & ~low_bit;
      busy_nxt = !is_last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_num_nxt   = out_num_r;
    out_level_nxt = out_level_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_num_nxt   = num[swde_pkg::SW_NUM_W-1:0];
      out_level_nxt = raw_r[low_idx];
      out_last_nxt  = is_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r      <= bank_nxt;
    rem_r       <= rem_nxt;
    raw_r       <= raw_nxt;
    out_num_r   <= out_num_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_switch_number = out_num_r;
  assign out_level         = out_level_r;
  assign out_last_event    = out_last_r;

endmodule

// ===== rtl/switch_word_debounce_events_top.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// in       | in_valid / in_stall | in_bank, in_raw_word, in_time_ms
// out      | out_valid/out_stall | out_switch_number, out_level, out_last_event
// cfg      | APB psel/penable    | paddr, pwdata, prdata (debounce_ms at 0x0)
//
// One scan is accepted per cycle while in_stall is low; its bank state
// updates in that same cycle. Each settled scan yields one event per changed
// bit, drained at one per cycle by the back end unless out_stall holds it.
// The front stalls only when the change queue (QUEUE_DEPTH entries) is full.
// Reset clears all bank state and sets debounce_ms to 50; out_stall holds the
// output register without blocking new scans until the queue fills.
module switch_word_debounce_events_top #(
  parameter int BANKS       = swde_pkg::BANKS_DEF,
  parameter int BANK_BITS   = swde_pkg::BANK_BITS_DEF,
  parameter int QUEUE_DEPTH = swde_pkg::QUEUE_DEPTH_DEF,
  parameter int BANK_W      = (BANKS > 1) ? $clog2(BANKS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swde_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [swde_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [swde_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [BANK_W-1:0]               in_bank,
  input  logic [BANK_BITS-1:0]            in_raw_word,
  input  logic [swde_pkg::TIME_W-1:0]     in_time_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [swde_pkg::SW_NUM_W-1:0]   out_switch_number,
  output logic                            out_level,
  output logic                            out_last_event
);

  localparam int ENTRY_W = BANK_W + 2 * BANK_BITS;

  logic [swde_pkg::DEBOUNCE_W-1:0] debounce_ms_r, debounce_ms_nxt;
  logic                            cfg_write;
  logic                            q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0]              q_wdata, q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == swde_pkg::REG_DEBOUNCE);
  assign debounce_ms_nxt = cfg_write ? pwdata[swde_pkg::DEBOUNCE_W-1:0] : debounce_ms_r;
  assign prdata = (paddr[2] == swde_pkg::REG_DEBOUNCE) ?
                  swde_pkg::CFG_DATA_W'(debounce_ms_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= swde_pkg::DEBOUNCE_RESET;
    end else begin
      debounce_ms_r <= debounce_ms_nxt;
    end
  end

  swde_front #(
    .BANKS     (BANKS),
    .BANK_BITS (BANK_BITS),
    .BANK_W    (BANK_W),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .debounce_ms (debounce_ms_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_bank     (in_bank),
    .in_raw_word (in_raw_word),
    .in_time_ms  (in_time_ms),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  swde_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  swde_back #(
    .BANKS     (BANKS),
    .BANK_BITS (BANK_BITS),
    .BANK_W    (BANK_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_switch_number (out_switch_number),
    .out_level         (out_level),
    .out_last_event    (out_last_event)
  );

endmodule
